[hw/rtl/tfb_pkg.sv]
// Package for the telemetry frame builder: constants and the burst type.
`timescale 1ns / 1ps

package tfb_pkg;

    localparam int unsigned MAX_PAYLOAD  = 28;
    localparam logic [7:0]  FRAME_HEADER = 8'h88;
    // Bytes still to come in a frame, up to MAX_PAYLOAD.
    localparam int unsigned LEFT_W       = $clog2(MAX_PAYLOAD + 1);
    // Most bytes one input word can produce.
    localparam int unsigned BURST_MAX    = 5;
    localparam int unsigned CNT_W        = $clog2(BURST_MAX + 1);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [BURST_MAX-1:0] bytes;     // bytes[0] goes out first
        logic  [CNT_W-1:0]     count;     // number of valid bytes
        logic                  last_end;  // last byte of the burst is the checksum
    } burst_t;

endpackage

[hw/rtl/tfb_if.sv]
// Handshake channels of the telemetry frame builder: input words and frame bytes.
`timescale 1ns / 1ps

interface tfb_item_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] function_code;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, frame_start, function_code, payload_length, data_byte,
                    input ready);
    modport sink   (input valid, frame_start, function_code, payload_length, data_byte,
                    output ready);
endinterface

interface tfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

[hw/rtl/telemetry_frame_builder.sv]
// Top level of the telemetry frame builder.
`timescale 1ns / 1ps
//
// Usage
//   item  : input words (frame_start, function_code, payload_length, data_byte).
//           A start word opens a frame; later data words each add one payload byte.
//   frame : output words, one frame byte each (out_byte, frame_end). frame_end
//           marks the checksum byte, the last of the frame.
// Order: the first byte produced by a word is offered in the cycle after the
//   word is accepted; the rest follow one per cycle while frame.ready is high.
// Burst: a word producing n bytes holds the burst register until all n are taken
//   (n from 0 to 5: five for a one-byte frame, four for a start, one or two
//   for a data word). A word producing nothing leaves the register free. The next word
//   is accepted in the cycle the last byte of the current burst is taken.
// Oversized lengths (above MAX_PAYLOAD) and data words while idle produce no
//   bytes. A start word during an open frame drops that frame unterminated.
// Reset: clears the frame state and empties the burst register; item.ready is
//   high straight after reset.
// Stall: while frame.ready is low the offered byte holds and item.ready stays
//   low once the burst register is occupied.

module telemetry_frame_builder (
    input  logic       clk,
    input  logic       rst_n,
    tfb_item_if.sink   item,
    tfb_byte_if.source frame
);
    import tfb_pkg::*;

    burst_t burst;
    logic   can_load;
    logic   accept;

    assign item.ready = can_load;
    assign accept     = item.valid && can_load;

    // state update and burst build for one word
    tfb_framer u_framer (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .frame_start    (item.frame_start),
        .function_code  (item.function_code),
        .payload_length (item.payload_length),
        .data_byte      (item.data_byte),
        .burst          (burst)
    );

    // burst register, one byte per cycle to the output while frame.ready is high
    tfb_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .burst    (burst),
        .can_load (can_load),
        .frame    (frame)
    );

endmodule

[hw/rtl/tfb_framer.sv]
// Frame state and the burst of bytes produced by one input word.
`timescale 1ns / 1ps

module tfb_framer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           frame_start,
    input  logic [7:0]     function_code,
    input  logic [7:0]     payload_length,
    input  logic [7:0]     data_byte,
    output tfb_pkg::burst_t burst
);
    import tfb_pkg::*;

    logic              in_frame_reg,    in_frame_next;
    logic [LEFT_W-1:0] bytes_left_reg,  bytes_left_next;
    byte_t             running_sum_reg, running_sum_next;

    byte_t             hdr_sum;
    byte_t             first_sum;
    byte_t             data_sum;
    logic [LEFT_W-1:0] left_dec;

    always_comb
    begin
        hdr_sum   = FRAME_HEADER + function_code + payload_length;
        first_sum = hdr_sum + data_byte;
        data_sum  = running_sum_reg + data_byte;
        left_dec  = bytes_left_reg - LEFT_W'(1);

        burst            = '0;
        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;

        if (frame_start)
        begin
            // any open frame is dropped without a checksum
            in_frame_next    = 1'b0;
            bytes_left_next  = '0;
            running_sum_next = '0;
            if (payload_length <= 8'(MAX_PAYLOAD))
            begin
                burst.bytes[0] = FRAME_HEADER;
                burst.bytes[1] = function_code;
                burst.bytes[2] = payload_length;
                if (payload_length == 8'd0)
                begin
                    burst.bytes[3] = hdr_sum;
                    burst.count    = CNT_W'(4);
                    burst.last_end = 1'b1;
                end
                else if (payload_length == 8'd1)
                begin
                    burst.bytes[3] = data_byte;
                    burst.bytes[4] = first_sum;
                    burst.count    = CNT_W'(5);
                    burst.last_end = 1'b1;
                end
                else
                begin
                    burst.bytes[3]   = data_byte;
                    burst.count      = CNT_W'(4);
                    in_frame_next    = 1'b1;
                    bytes_left_next  = LEFT_W'(payload_length - 8'd1);
                    running_sum_next = first_sum;
                end
            end
        end
        else if (in_frame_reg && (bytes_left_reg != '0))
        begin
            burst.bytes[0] = data_byte;
            if (left_dec == '0)
            begin
                burst.bytes[1]   = data_sum;
                burst.count      = CNT_W'(2);
                burst.last_end   = 1'b1;
                in_frame_next    = 1'b0;
                bytes_left_next  = '0;
                running_sum_next = '0;
            end
            else
            begin
                burst.count      = CNT_W'(1);
                bytes_left_next  = left_dec;
                running_sum_next = data_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (accept)
        begin
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

[hw/rtl/tfb_serializer.sv]
// Burst register and byte-at-a-time output of the telemetry frame builder.
`timescale 1ns / 1ps

module tfb_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  tfb_pkg::burst_t burst,
    output logic            can_load,
    tfb_byte_if.source      frame
);
    import tfb_pkg::*;

    byte_t [BURST_MAX-1:0] bytes_reg;
    logic  [CNT_W-1:0]     count_reg;
    logic  [CNT_W-1:0]     idx_reg, idx_next;
    logic                  end_reg;
    logic                  take;
    logic                  on_last;
    logic  [2:0]           sel;

    assign on_last  = (idx_reg == count_reg - CNT_W'(1));
    assign take     = frame.valid && frame.ready;
    assign can_load = (idx_reg == count_reg) || (take && on_last);
    assign sel      = 3'(idx_reg);

    assign frame.valid     = (idx_reg != count_reg);
    assign frame.out_byte  = bytes_reg[sel];
    assign frame.frame_end = frame.valid && end_reg && on_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= burst.count;
            idx_reg   <= '0;
            end_reg   <= burst.last_end;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= burst.bytes;
        end
    end

    // never load over a burst that still has bytes to send
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (idx_reg == count_reg) || (take && on_last))
        else $error("burst loaded over unsent bytes");

    // index never runs past the burst
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= count_reg) && (count_reg <= CNT_W'(BURST_MAX)))
        else $error("burst index out of range");

    // a checksum word ends the frame, so the next word goes out only after a reload
    a_end_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.frame_end && frame.ready && !load) |=> !frame.valid)
        else $error("word sent after frame end without reload");

    // a stalled word does not advance the index
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && !frame.ready && !load) |=> $stable(idx_reg))
        else $error("index moved while stalled");

endmodule

[test/telemetry_frame_builder_tb.sv]
// Testbench for the telemetry frame builder: random and directed words, byte-level scoreboard.
`timescale 1ns / 1ps

module telemetry_frame_builder_tb;

    import tfb_pkg::*;

    // No handshake on either channel for this many cycles means the block is stuck.
    localparam int unsigned STUCK_LIMIT   = 2000;
    // Receiver holds off this long, twice, while the sender keeps offering.
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned HOLD_AT_FIRST = 60;
    localparam int unsigned HOLD_AT_LATER = 110;
    // Random words that actually drive the frame logic.
    localparam int unsigned RANDOM_WORDS  = 70;
    // Cycles to watch for stray bytes once nothing more is due.
    localparam int unsigned SETTLE_CYCLES = 20;

    // Receiver stall behaviour, re-chosen at random by the byte receiver.
    typedef enum logic [1:0] {
        RX_STREAM,  // always ready
        RX_CHOPPY,  // ready half the time
        RX_SPARSE   // ready a quarter of the time
    } rx_mode_t;

    typedef struct {
        logic  frame_start;
        byte_t function_code;
        byte_t payload_length;
        byte_t data_byte;
        bit    drain_first;     // hold this word back until every due byte has arrived
    } word_t;

    typedef struct {
        byte_t value;
        logic  closes;          // checksum byte, frame_end expected high
    } frame_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Stimulus side, held in plain variables so every input is known from time zero.
    logic  drv_valid = 1'b0;
    logic  drv_start = 1'b0;
    byte_t drv_code  = '0;
    byte_t drv_len   = '0;
    byte_t drv_data  = '0;
    logic  rcv_ready = 1'b0;

    tfb_item_if item_bus ();
    tfb_byte_if frame_bus ();

    assign item_bus.valid          = drv_valid;
    assign item_bus.frame_start    = drv_start;
    assign item_bus.function_code  = drv_code;
    assign item_bus.payload_length = drv_len;
    assign item_bus.data_byte      = drv_data;
    assign frame_bus.ready         = rcv_ready;

    telemetry_frame_builder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .frame (frame_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared state between stimulus, driver, predictor and checker
    // ------------------------------------------------------------------
    word_t       pending_words[$];     // words not yet offered
    frame_byte_t frame_bytes_due[$];   // predicted bytes, oldest first
    int unsigned bytes_due   = 0;      // size of the above as of the last edge
    logic        sender_done = 1'b0;   // all words accepted, nothing on offer
    int unsigned mismatches  = 0;

    // Predictor's own copy of the framing state.
    bit                open_frame   = 1'b0;
    logic [LEFT_W-1:0] payload_left = '0;
    byte_t             sum_so_far   = '0;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------
    function automatic void emit_byte(input byte_t value, input logic closes);
        frame_byte_t b;
        b.value  = value;
        b.closes = closes;
        frame_bytes_due.push_back(b);
        sum_so_far = sum_so_far + value;
    endfunction

    // Checksum closes the frame and returns the predictor to idle.
    function automatic void emit_checksum();
        emit_byte(sum_so_far, 1'b1);
        open_frame   = 1'b0;
        payload_left = '0;
        sum_so_far   = '0;
    endfunction

    function automatic void predict_frame(input word_t w);
        if (w.frame_start)
        begin
            // a start word always abandons whatever frame was open
            open_frame   = 1'b0;
            payload_left = '0;
            sum_so_far   = '0;
            if (w.payload_length > MAX_PAYLOAD)
                return;             // oversized: dropped without a trace
            emit_byte(FRAME_HEADER, 1'b0);
            emit_byte(w.function_code, 1'b0);
            emit_byte(w.payload_length, 1'b0);
            if (w.payload_length == 0)
            begin
                emit_checksum();    // data_byte plays no part here
                return;
            end
            emit_byte(w.data_byte, 1'b0);
            payload_left = LEFT_W'(w.payload_length - 1);
            if (payload_left == 0)
                emit_checksum();
            else
                open_frame = 1'b1;
        end
        else if (open_frame && payload_left != 0)
        begin
            emit_byte(w.data_byte, 1'b0);
            payload_left = payload_left - 1'b1;
            if (payload_left == 0)
                emit_checksum();
        end
        // data words while idle leave no mark
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic start, input byte_t code, input byte_t len,
                             input byte_t data, input bit drain);
        word_t w;
        w.frame_start    = start;
        w.function_code  = code;
        w.payload_length = len;
        w.data_byte      = data;
        w.drain_first    = drain;
        pending_words.push_back(w);
    endtask

    // Start word then data_words data words; code and length on data words are noise.
    task automatic queue_frame(input byte_t code, input byte_t len, input int data_words,
                               input bit drain);
        push_word(1'b1, code, len, byte_t'($urandom), drain);
        for (int i = 0; i < data_words; i++)
            push_word(1'b0, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Word driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        word_t nxt;
        logic  offer;
        if (!rst_n)
        begin
            drv_valid   <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
            sender_done <= 1'b0;
        end
        else if (!drv_valid || item_bus.ready)
        begin
            // slot is free after this edge: decide what to offer next
            offer = 1'b0;
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (pending_words.size() != 0)
            begin
                // a drain word waits until the checker has every due byte
                if (!(pending_words[0].drain_first && (drv_valid || bytes_due != 0)))
                begin
                    nxt       = pending_words.pop_front();
                    drv_start <= nxt.frame_start;
                    drv_code  <= nxt.function_code;
                    drv_len   <= nxt.payload_length;
                    drv_data  <= nxt.data_byte;
                    offer     = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        // a third of bursts run straight into the next one
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            drv_valid   <= offer;
            sender_done <= (pending_words.size() == 0) && !offer;
        end
    end

    // ------------------------------------------------------------------
    // Byte receiver: its own stall pattern plus two long hold-offs
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode    = RX_STREAM;
    int unsigned rx_cycle   = 0;
    int unsigned words_seen = 0;
    int unsigned hold_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin : byte_sink
        int unsigned seen_now;
        if (!rst_n)
        begin
            rcv_ready  <= 1'b0;
            rx_mode    <= RX_STREAM;
            rx_cycle   <= 0;
            words_seen <= 0;
            hold_left  <= 0;
        end
        else
        begin
            seen_now = words_seen;
            if (item_bus.valid && item_bus.ready)
                seen_now = seen_now + 1;
            words_seen <= seen_now;
            rx_cycle   <= rx_cycle + 1;
            if (rx_cycle % 64 == 63)
                rx_mode <= rx_mode_t'($urandom_range(0, 2));

            if (seen_now != words_seen &&
                (seen_now == HOLD_AT_FIRST || seen_now == HOLD_AT_LATER))
            begin
                // long hold-off: burst register fills, item.ready must drop
                hold_left <= LONG_HOLD;
                rcv_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rcv_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM: rcv_ready <= 1'b1;
                    RX_CHOPPY: rcv_ready <= 1'($urandom_range(0, 1));
                    default:   rcv_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: byte compare first, then predict from the accepted word.
    // A word's bytes never leave in the cycle it is accepted, so the
    // order of the two within an edge does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : frame_checker
        frame_byte_t want;
        word_t       got_word;
        if (!rst_n)
        begin
            open_frame   = 1'b0;
            payload_left = '0;
            sum_so_far   = '0;
            bytes_due   <= 0;
        end
        else
        begin
            if (frame_bus.valid && frame_bus.ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %02h frame_end %0b, nothing due",
                             $time, frame_bus.out_byte, frame_bus.frame_end);
                    mismatches++;
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (frame_bus.out_byte !== want.value)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.value, frame_bus.out_byte);
                        mismatches++;
                    end
                    if (frame_bus.frame_end !== want.closes)
                    begin
                        $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                                 $time, want.closes, frame_bus.frame_end);
                        mismatches++;
                    end
                end
            end
            if (item_bus.valid && item_bus.ready)
            begin
                got_word.frame_start    = item_bus.frame_start;
                got_word.function_code  = item_bus.function_code;
                got_word.payload_length = item_bus.payload_length;
                got_word.data_byte      = item_bus.data_byte;
                got_word.drain_first    = 1'b0;
                predict_frame(got_word);
            end
            bytes_due <= frame_bytes_due.size();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either side
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (frame_bus.valid && frame_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d bytes still due",
                         $time, quiet_cycles, frame_bytes_due.size());
                $display("FAIL telemetry_frame_builder");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned useful;
        int unsigned pick;
        int unsigned len;
        int unsigned data_words;
        bit          drain;

        // Directed words
        push_word(1'b0, 8'h5A, 8'h03, 8'hC3, 1'b0);   // data while idle straight after reset
        push_word(1'b1, 8'h00, 8'h00, 8'hFF, 1'b0);   // zero length, data byte ignored
        push_word(1'b1, 8'hFF, 8'h00, 8'h00, 1'b0);
        push_word(1'b1, 8'hA5, 8'h01, 8'h5A, 1'b0);   // length one: five bytes in one go
        push_word(1'b1, 8'hFF, 8'h01, 8'hFF, 1'b0);
        push_word(1'b1, 8'h12, 8'd29, 8'h34, 1'b0);   // one past the limit: dropped
        push_word(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);   // largest length: dropped
        push_word(1'b0, 8'hFF, 8'hFF, 8'h77, 1'b0);   // data after a dropped frame
        push_word(1'b1, 8'h01, 8'h03, 8'h00, 1'b0);   // ordinary three-byte frame
        push_word(1'b0, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_word(1'b0, 8'h00, 8'h00, 8'h80, 1'b0);
        push_word(1'b0, 8'h00, 8'h00, 8'h99, 1'b0);   // data after the checksum
        push_word(1'b1, 8'h7E, 8'h05, 8'h11, 1'b0);   // frame cut short by a restart
        push_word(1'b0, 8'h00, 8'h00, 8'h22, 1'b0);
        push_word(1'b1, 8'h33, 8'h02, 8'h44, 1'b0);
        push_word(1'b0, 8'h00, 8'h00, 8'h55, 1'b0);
        push_word(1'b1, 8'h40, 8'h02, 8'h01, 1'b0);   // restart into a zero-length frame
        push_word(1'b1, 8'h41, 8'h00, 8'h02, 1'b0);
        push_word(1'b1, 8'h42, 8'h04, 8'h03, 1'b0);   // restart into an oversized frame
        push_word(1'b1, 8'h43, 8'h80, 8'h04, 1'b0);
        push_word(1'b0, 8'h00, 8'h00, 8'h05, 1'b1);   // idle data, after a full drain

        // Longest frame, after the pipeline has emptied
        queue_frame(byte_t'($urandom), byte_t'(MAX_PAYLOAD), MAX_PAYLOAD - 1, 1'b1);

        // Random part: mostly well-formed frames, some broken, oversized or stray
        useful = 0;
        while (useful < RANDOM_WORDS)
        begin
            pick  = $urandom_range(0, 19);
            drain = ($urandom_range(0, 14) == 0);
            if (pick < 14)
            begin
                // short frames dominate; one in six anywhere up to the limit
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                  : $urandom_range(0, 6);
                data_words = (len == 0) ? 0 : len - 1;
                queue_frame(byte_t'($urandom), byte_t'(len), data_words, drain);
                useful += 1 + data_words;
            end
            else if (pick < 16)
            begin
                // truncated: the next start abandons it
                len        = $urandom_range(2, 10);
                data_words = $urandom_range(0, len - 2);
                queue_frame(byte_t'($urandom), byte_t'(len), data_words, drain);
                useful += 1 + data_words;
            end
            else if (pick < 18)
            begin
                // oversized start, trailing data words are noise
                len = $urandom_range(MAX_PAYLOAD + 1, 255);
                queue_frame(byte_t'($urandom), byte_t'(len), $urandom_range(0, 2), drain);
                useful += 1;
            end
            else
                push_word(1'b0, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                          drain);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all words accepted and every predicted byte seen
        do
            @(posedge clk);
        while (!(sender_done && bytes_due == 0));

        // watch a little longer for stray bytes
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (frame_bytes_due.size() != 0)
        begin
            $display("%0t: %0d predicted bytes never arrived", $time, frame_bytes_due.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("PASS telemetry_frame_builder");
        else
            $display("FAIL telemetry_frame_builder");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tfb_pkg.sv
hw/rtl/tfb_if.sv
hw/rtl/tfb_framer.sv
hw/rtl/tfb_serializer.sv
hw/rtl/telemetry_frame_builder.sv
test/telemetry_frame_builder_tb.sv
